// ===== hdl/wed_pkg.sv =====
`timescale 1ns / 1ps

package wed_pkg;

    // Operation codes carried by the func field of an input word.
    typedef enum logic [1:0] {
        FUNC_APPEND_SECOND = 2'd0,
        FUNC_APPEND_FIRST  = 2'd1,
        FUNC_FINISH        = 2'd2
    } func_t;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] CFG_INSERT  = 2'd0;
    localparam logic [1:0] CFG_REPLACE = 2'd1;
    localparam logic [1:0] CFG_DELETE  = 2'd2;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int COST_W    = 16;
    localparam int DIST_W    = 24;
    localparam int BYTE_W    = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
    localparam logic [COST_W-1:0] COST_ONE = 16'd1;

    typedef struct packed {
        logic [COST_W-1:0] insert_cost;
        logic [COST_W-1:0] replace_cost;
        logic [COST_W-1:0] delete_cost;
    } cost_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_CELL_RD,
        ST_CELL_A,
        ST_CELL_B,
        ST_CELL_C,
        ST_DONE
    } state_t;

    // A cost register written as zero behaves as a cost of one.
    function automatic logic [COST_W-1:0] eff_cost(input logic [COST_W-1:0] c);
        return (c == '0) ? COST_ONE : c;
    endfunction

endpackage

// ===== hdl/wed_regs.sv =====
`timescale 1ns / 1ps

module wed_regs
    import wed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cost_t             costs
);

    cost_t      costs_reg;
    cost_t      costs_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign costs   = costs_reg;

    always_comb
    begin
        costs_next = costs_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                CFG_INSERT:  costs_next.insert_cost  = pwdata[COST_W-1:0];
                CFG_REPLACE: costs_next.replace_cost = pwdata[COST_W-1:0];
                CFG_DELETE:  costs_next.delete_cost  = pwdata[COST_W-1:0];
                default:     costs_next = costs_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            CFG_INSERT:  prdata = APB_DW'(costs_reg.insert_cost);
            CFG_REPLACE: prdata = APB_DW'(costs_reg.replace_cost);
            CFG_DELETE:  prdata = APB_DW'(costs_reg.delete_cost);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            costs_reg.insert_cost  <= COST_ONE;
            costs_reg.replace_cost <= COST_ONE;
            costs_reg.delete_cost  <= COST_ONE;
        end
        else
        begin
            costs_reg <= costs_next;
        end
    end

endmodule

// ===== hdl/weighted_edit_distance_top.sv =====
`timescale 1ns / 1ps

// Weighted byte edit distance. Byte loads (func 0 for the second string, func 1 for the
// first) are taken one word per cycle while the sequencer is idle. A finish word runs
// the one-row dynamic programme through a single shared add-and-compare unit: each
// cell reads the row store and the second string in ST_CELL_RD, then forms left+insert,
// above+delete and diagonal+replace in ST_CELL_A, ST_CELL_B and ST_CELL_C, with the
// input stalled throughout a finish. A finish after an overloaded string returns
// status 1 and distance 0 through ST_DONE. Distances saturate at 0xFFFFFF. A result
// left waiting on the output does not block byte loads.

module weighted_edit_distance_top
    import wed_pkg::*;
#(
    parameter int MAX_LEN = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [BYTE_W-1:0] byte_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DIST_W-1:0] distance,
    output logic              status
);

    localparam int LenW  = $clog2(MAX_LEN + 1);
    localparam int StrAw = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CellW = $clog2(2 * MAX_LEN * 65536);
    localparam int SatW  = (CellW > DIST_W) ? CellW : DIST_W;
    localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LEN);

    cost_t costs;

    wed_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .costs   (costs)
    );

    logic [CellW-1:0] ci;
    logic [CellW-1:0] cr;
    logic [CellW-1:0] cd;

    assign ci = CellW'(eff_cost(costs.insert_cost));
    assign cr = CellW'(eff_cost(costs.replace_cost));
    assign cd = CellW'(eff_cost(costs.delete_cost));

    state_t            state_reg, state_next;
    logic [LenW-1:0]   i_reg, i_next;
    logic [LenW-1:0]   j_reg, j_next;
    logic [LenW-1:0]   first_len_reg, first_len_next;
    logic [LenW-1:0]   second_len_reg, second_len_next;
    logic              ovf_reg, ovf_next;
    logic [CellW-1:0]  left_reg, left_next;
    logic [CellW-1:0]  base_reg, base_next;
    logic [CellW-1:0]  best_reg, best_next;
    logic [CellW-1:0]  diag_reg, diag_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              status_reg, status_next;

    // String and row memories.
    logic [BYTE_W-1:0] first_mem  [MAX_LEN];
    logic [BYTE_W-1:0] second_mem [MAX_LEN];
    logic [CellW-1:0]  row_mem    [MAX_LEN + 1];
    logic [BYTE_W-1:0] first_rd_reg;
    logic [BYTE_W-1:0] second_rd_reg;
    logic [CellW-1:0]  row_rd_reg;

    logic              first_we, second_we;
    logic [StrAw-1:0]  first_waddr, second_waddr;
    logic              first_re, second_re, row_re, row_we;
    logic [StrAw-1:0]  first_raddr, second_raddr;
    logic [LenW-1:0]   row_raddr, row_waddr;
    logic [CellW-1:0]  row_wdata;
    logic [LenW-1:0]   i_m1, j_m1;

    // Shared add-and-compare unit.
    logic [CellW-1:0]  op_a, op_b, op_sum;
    logic              op_lt;
    logic [CellW-1:0]  cell_min;

    logic              in_take;
    logic              out_free;
    logic              bytes_match;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign distance    = distance_reg;
    assign status      = status_reg;
    assign i_m1        = i_reg - 1'b1;
    assign j_m1        = j_reg - 1'b1;
    assign bytes_match = (first_rd_reg == second_rd_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_INIT, ST_CELL_A:
            begin
                op_a = left_reg;
                op_b = ci;
            end
            ST_ROW_WR:
            begin
                op_a = base_reg;
                op_b = cd;
            end
            ST_CELL_B:
            begin
                op_a = row_rd_reg;
                op_b = cd;
            end
            ST_CELL_C:
            begin
                op_a = diag_reg;
                op_b = bytes_match ? '0 : cr;
            end
            default:
            begin
                op_a = left_reg;
                op_b = '0;
            end
        endcase
    end

    assign op_sum   = op_a + op_b;
    assign op_lt    = (op_sum < best_reg);
    assign cell_min = op_lt ? op_sum : best_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (func == FUNC_FINISH))
                begin
                    state_next = ovf_reg ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (j_reg == second_len_reg)
                begin
                    state_next = (first_len_reg == '0) ? ST_DONE : ST_ROW_RD;
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_WR;
            end
            ST_ROW_WR:
            begin
                if (second_len_reg != '0)
                begin
                    state_next = ST_CELL_RD;
                end
                else
                begin
                    state_next = (i_reg == first_len_reg) ? ST_DONE : ST_ROW_RD;
                end
            end
            ST_CELL_RD:
            begin
                state_next = ST_CELL_A;
            end
            ST_CELL_A:
            begin
                state_next = ST_CELL_B;
            end
            ST_CELL_B:
            begin
                state_next = ST_CELL_C;
            end
            ST_CELL_C:
            begin
                if (j_reg == second_len_reg)
                begin
                    state_next = (i_reg == first_len_reg) ? ST_DONE : ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        left_next       = left_reg;
        base_next       = base_reg;
        best_next       = best_reg;
        diag_next       = diag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        distance_next   = distance_reg;
        status_next     = status_reg;
        first_we        = 1'b0;
        second_we       = 1'b0;
        first_waddr     = first_len_reg[StrAw-1:0];
        second_waddr    = second_len_reg[StrAw-1:0];
        first_re        = 1'b0;
        second_re       = 1'b0;
        row_re          = 1'b0;
        row_we          = 1'b0;
        first_raddr     = i_m1[StrAw-1:0];
        second_raddr    = j_m1[StrAw-1:0];
        row_raddr       = j_reg;
        row_waddr       = j_reg;
        row_wdata       = left_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    unique case (func)
                        FUNC_APPEND_SECOND:
                        begin
                            if (second_len_reg < MaxLen)
                            begin
                                second_we       = 1'b1;
                                second_len_next = second_len_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_APPEND_FIRST:
                        begin
                            if (first_len_reg < MaxLen)
                            begin
                                first_we       = 1'b1;
                                first_len_next = first_len_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_FINISH:
                        begin
                            j_next    = '0;
                            left_next = '0;
                        end
                        default:
                        begin
                            ovf_next = ovf_reg;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                row_we    = 1'b1;
                row_wdata = left_reg;
                if (j_reg != second_len_reg)
                begin
                    left_next = op_sum;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    i_next    = LenW'(1);
                    base_next = '0;
                end
            end
            ST_ROW_RD:
            begin
                row_re    = 1'b1;
                first_re  = 1'b1;
                row_raddr = '0;
            end
            ST_ROW_WR:
            begin
                diag_next = row_rd_reg;
                base_next = op_sum;
                left_next = op_sum;
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = op_sum;
                j_next    = LenW'(1);
                if ((second_len_reg == '0) && (i_reg != first_len_reg))
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_CELL_RD:
            begin
                row_re    = 1'b1;
                second_re = 1'b1;
            end
            ST_CELL_A:
            begin
                best_next = op_sum;
            end
            ST_CELL_B:
            begin
                best_next = cell_min;
            end
            ST_CELL_C:
            begin
                row_we    = 1'b1;
                row_wdata = cell_min;
                left_next = cell_min;
                diag_next = row_rd_reg;
                if (j_reg != second_len_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else if (i_reg != first_len_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = ovf_reg;
                    if (ovf_reg)
                    begin
                        distance_next = '0;
                    end
                    else if (SatW'(left_reg) > SatW'(DIST_MAX))
                    begin
                        distance_next = DIST_MAX;
                    end
                    else
                    begin
                        distance_next = DIST_W'(SatW'(left_reg));
                    end
                    first_len_next  = '0;
                    second_len_next = '0;
                    ovf_next        = 1'b0;
                end
            end
            default:
            begin
                ovf_next = ovf_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_waddr] <= byte_value;
        end
        if (first_re)
        begin
            first_rd_reg <= first_mem[first_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_waddr] <= byte_value;
        end
        if (second_re)
        begin
            second_rd_reg <= second_mem[second_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_rd_reg <= row_mem[row_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        left_reg     <= left_next;
        base_reg     <= base_next;
        best_reg     <= best_next;
        diag_reg     <= diag_next;
        distance_reg <= distance_next;
        status_reg   <= status_next;
    end

    // A new result only appears after the sequencer has finished.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    // An overflow result always carries a zero distance.
    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (distance_reg == '0))
        else $error("overflow result with non-zero distance");

    // Cell updates stay inside the loaded second string.
    a_cell_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL_C) |-> ((j_reg != '0) && (j_reg <= second_len_reg)))
        else $error("cell column out of range");

    // Lengths never pass the string capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= MaxLen) && (second_len_reg <= MaxLen))
        else $error("string length beyond capacity");

    // A finish word always starts the sequencer.
    a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (func == FUNC_FINISH)) |=> (state_reg != ST_IDLE))
        else $error("finish word did not start the sequencer");

endmodule
